>>> hw/rtl/mesf_pkg.sv
package mesf_pkg;

  // Frame geometry and configuration
  localparam int DIM_W   = 12;
  localparam int LIMIT_W = 16;
  localparam int SUM_W   = 38;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_LIMIT = 2'd2;

  localparam logic [DIM_W-1:0]   RST_FRAME_WIDTH     = 12'd426;
  localparam logic [DIM_W-1:0]   RST_FRAME_HEIGHT    = 12'd240;
  localparam logic [LIMIT_W-1:0] RST_ITERATION_LIMIT = 16'd100;

  // Start queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Pixel to point mapping, millionths
  localparam int COORD_W = 23;
  localparam int SDIV_Q_W = 22;
  localparam int SDIV_N_W = SDIV_Q_W + DIM_W;
  localparam int SDIV_STEPS = SDIV_Q_W;
  localparam int SDIV_CNT_W = $clog2(SDIV_STEPS + 1);

  localparam logic [SDIV_Q_W-1:0] CR_SPAN = 22'd3500000;
  localparam logic [SDIV_Q_W-1:0] CI_SPAN = 22'd2000000;
  localparam logic signed [COORD_W-1:0] CR_OFS = 23'sd2500000;
  localparam logic signed [COORD_W-1:0] CI_OFS = 23'sd1000000;

  // Iteration datapath
  localparam int Z_W    = 24;
  localparam int PROD_W = 2 * Z_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int QUO_W  = 30;
  localparam int ACC_W  = 31;

  // Division by one million: a shift by six, then division by 15625 through
  // a reciprocal split into two partial products and one correction step.
  localparam int FX_SHIFT = 6;
  localparam int CDIV_M_W = PROD_W - FX_SHIFT;
  localparam int CDIV_LO_W = CDIV_M_W / 2;
  localparam int CDIV_HI_W = CDIV_M_W - CDIV_LO_W;
  localparam int RECIP_SHIFT = CDIV_M_W;
  localparam int RECIP_W = 29;
  localparam int PP_W = CDIV_HI_W + RECIP_W;
  localparam int CDIV_SUM_W = PP_W + CDIV_LO_W;
  localparam int CDIV_LAT = 5;
  localparam logic [13:0] FX_ODD = 14'd15625;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd15625);

  localparam logic signed [ACC_W-1:0] ESC_LIMIT = 31'sd4000000;

  typedef struct packed {
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
    logic [LIMIT_W-1:0] iteration_limit;
  } cfg_t;

  typedef struct packed {
    cfg_t cfg;
    logic pend;
  } fe_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ROW,
    BK_ROW_WAIT,
    BK_PIX,
    BK_PIX_WAIT,
    BK_MUL,
    BK_DGO,
    BK_DWAIT,
    BK_PEND,
    BK_DONE
  } bk_state_t;

endpackage

>>> hw/rtl/mesf_front.sv
module mesf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [0] start_req
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mesf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mesf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                pop_i,
  output mesf_pkg::fe_t                       fe_o
);

  mesf_pkg::cfg_t                  cfg_r, cfg_nxt;
  logic [mesf_pkg::QCNT_W-1:0]     cnt_r, cnt_nxt;
  logic                            push;

  assign cfg_ready = 1'b1;
  assign in_tready = (cnt_r != mesf_pkg::QCNT_W'(mesf_pkg::QUEUE_DEPTH));

  // Words without a start request are taken and dropped here.
  assign push = in_tvalid & in_tready & in_tdata[0];

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        mesf_pkg::CFG_FRAME_WIDTH:
          cfg_nxt.frame_width = cfg_data[mesf_pkg::DIM_W-1:0];
        mesf_pkg::CFG_FRAME_HEIGHT:
          cfg_nxt.frame_height = cfg_data[mesf_pkg::DIM_W-1:0];
        mesf_pkg::CFG_ITERATION_LIMIT:
          cfg_nxt.iteration_limit = cfg_data[mesf_pkg::LIMIT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  assign cnt_nxt = cnt_r + mesf_pkg::QCNT_W'(push) - mesf_pkg::QCNT_W'(pop_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width     <= mesf_pkg::RST_FRAME_WIDTH;
      cfg_r.frame_height    <= mesf_pkg::RST_FRAME_HEIGHT;
      cfg_r.iteration_limit <= mesf_pkg::RST_ITERATION_LIMIT;
      cnt_r                 <= '0;
    end else begin
      cfg_r <= cfg_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign fe_o.cfg  = cfg_r;
  assign fe_o.pend = (cnt_r != '0);

endmodule

>>> hw/rtl/mesf_sdiv.sv
module mesf_sdiv (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start_i,
  input  logic [mesf_pkg::SDIV_N_W-1:0]      dividend_i,
  input  logic [mesf_pkg::DIM_W-1:0]         divisor_i,
  output logic                               done_o,
  output logic [mesf_pkg::SDIV_Q_W-1:0]      quo_o
);

  localparam int QW = mesf_pkg::SDIV_Q_W;
  localparam int DW = mesf_pkg::DIM_W;

  logic [DW-1:0]                    rem_r, rem_nxt;
  logic [QW-1:0]                    dvd_r, dvd_nxt;
  logic [DW-1:0]                    dvs_r, dvs_nxt;
  logic [mesf_pkg::SDIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                             run_r, run_nxt;
  logic                             done_r, done_nxt;
  logic [DW:0]                      trial;
  logic                             ge;
  logic [DW-1:0]                    rem_step;

  // The quotient is known to fit in QW bits, so the upper dividend bits
  // already form a partial remainder below the divisor.
  always_comb begin
    trial    = {rem_r, dvd_r[QW-1]};
    ge       = (trial >= {1'b0, dvs_r});
    rem_step = ge ? DW'(trial - {1'b0, dvs_r}) : trial[DW-1:0];
  end

  always_comb begin
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start_i) begin
      rem_nxt = dividend_i[mesf_pkg::SDIV_N_W-1:QW];
      dvd_nxt = dividend_i[QW-1:0];
      dvs_nxt = divisor_i;
      cnt_nxt = mesf_pkg::SDIV_CNT_W'(mesf_pkg::SDIV_STEPS);
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt  = rem_step;
      dvd_nxt  = {dvd_r[QW-2:0], ge};
      cnt_nxt  = cnt_r - 1'b1;
      run_nxt  = (cnt_r != mesf_pkg::SDIV_CNT_W'(1));
      done_nxt = (cnt_r == mesf_pkg::SDIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done_o = done_r;
  assign quo_o  = dvd_r;

endmodule

>>> hw/rtl/mesf_cdiv.sv
module mesf_cdiv (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   vld_i,
  input  logic signed [mesf_pkg::NUM_W-1:0]      num_i,
  output logic                                   vld_o,
  output logic signed [mesf_pkg::QUO_W-1:0]      quo_o
);

  localparam int MW = mesf_pkg::CDIV_M_W;
  localparam int LW = mesf_pkg::CDIV_LO_W;
  localparam int RW = mesf_pkg::RECIP_W;

  logic [mesf_pkg::CDIV_LAT-1:0]  vld_r;
  logic [mesf_pkg::NUM_W-1:0]     mag;
  logic [mesf_pkg::CDIV_SUM_W-1:0] sum3;
  logic [MW-1:0]                  rem4;

  logic                           neg1_r, neg2_r, neg3_r, neg4_r;
  logic [MW-1:0]                  m1_r, m2_r, m3_r;
  logic [mesf_pkg::PP_W-1:0]      pph_r, ppl_r;
  logic [RW-1:0]                  q3_r, q4_r;
  logic signed [mesf_pkg::QUO_W-1:0] quo_r;

  always_comb begin
    mag  = num_i[mesf_pkg::NUM_W-1] ? mesf_pkg::NUM_W'(-num_i)
                                    : mesf_pkg::NUM_W'(num_i);
    sum3 = {pph_r, LW'(0)} + mesf_pkg::CDIV_SUM_W'(ppl_r);
    rem4 = m3_r - MW'(q3_r * mesf_pkg::FX_ODD);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[mesf_pkg::CDIV_LAT-2:0], vld_i};
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  always_ff @(posedge clk) begin
    neg1_r <= num_i[mesf_pkg::NUM_W-1];
    m1_r   <= mag[mesf_pkg::PROD_W-1:mesf_pkg::FX_SHIFT];

    neg2_r <= neg1_r;
    m2_r   <= m1_r;
    pph_r  <= mesf_pkg::PP_W'(m1_r[MW-1:LW] * mesf_pkg::RECIP);
    ppl_r  <= mesf_pkg::PP_W'(m1_r[LW-1:0] * mesf_pkg::RECIP);

    neg3_r <= neg2_r;
    m3_r   <= m2_r;
    q3_r   <= sum3[mesf_pkg::CDIV_SUM_W-1:mesf_pkg::RECIP_SHIFT];

    // The reciprocal estimate is at most one below the true quotient.
    neg4_r <= neg3_r;
    q4_r   <= (rem4 >= MW'(mesf_pkg::FX_ODD)) ? q3_r + 1'b1 : q3_r;

    quo_r  <= neg4_r ? -$signed({1'b0, q4_r}) : $signed({1'b0, q4_r});
  end

  assign vld_o = vld_r[mesf_pkg::CDIV_LAT-1];
  assign quo_o = quo_r;

endmodule

>>> hw/rtl/mesf_back.sv
module mesf_back (
  input  logic              clk,
  input  logic              rst_n,
  input  mesf_pkg::fe_t     fe_i,
  output logic              pop_o,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [39:0]       out_tdata
);

  localparam int DW = mesf_pkg::DIM_W;
  localparam int ZW = mesf_pkg::Z_W;
  localparam int AW = mesf_pkg::ACC_W;

  mesf_pkg::bk_state_t state_r, state_nxt;

  logic [DW-1:0]                        x_r, x_nxt, y_r, y_nxt;
  logic signed [mesf_pkg::COORD_W-1:0]  cr_r, cr_nxt, ci_r, ci_nxt;
  logic signed [ZW-1:0]                 zr_r, zr_nxt, zi_r, zi_nxt;
  logic [mesf_pkg::LIMIT_W-1:0]         n_r, n_nxt;
  logic [mesf_pkg::SUM_W-1:0]           sum_r, sum_nxt;
  logic signed [mesf_pkg::PROD_W-1:0]   prr_r, prr_nxt, pii_r, pii_nxt, pri_r, pri_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [mesf_pkg::SUM_W-1:0]           out_data_r, out_data_nxt;

  logic                                 sd_start, sd_done;
  logic [DW-1:0]                        sd_op, sd_divisor;
  logic [mesf_pkg::SDIV_Q_W-1:0]        sd_cst, sd_quo;
  logic [mesf_pkg::SDIV_N_W-1:0]        sd_dividend;

  logic                                 cd_vld;
  logic                                 cd_done_rr, cd_done_ii, cd_done_ri, cd_done;
  logic signed [mesf_pkg::QUO_W-1:0]    zr2, zi2, zrzi2;
  logic signed [AW-1:0]                 mag2, zr_new, zi_new;
  logic                                 escape;
  logic                                 empty_frame, last_x, last_y, at_limit, out_free;
  logic                                 out_load;

  assign empty_frame = (fe_i.cfg.frame_width == '0) || (fe_i.cfg.frame_height == '0);
  assign last_x      = (x_r == fe_i.cfg.frame_width - 1'b1);
  assign last_y      = (y_r == fe_i.cfg.frame_height - 1'b1);
  assign at_limit    = (n_r == fe_i.cfg.iteration_limit);
  assign out_free    = !out_valid_r || out_tready;

  // Coordinate divider: one product per row for ci, one per pixel for cr.
  always_comb begin
    sd_op       = (state_r == mesf_pkg::BK_ROW) ? y_r : x_r;
    sd_cst      = (state_r == mesf_pkg::BK_ROW) ? mesf_pkg::CI_SPAN : mesf_pkg::CR_SPAN;
    sd_divisor  = (state_r == mesf_pkg::BK_ROW) ? fe_i.cfg.frame_height
                                                : fe_i.cfg.frame_width;
    sd_dividend = mesf_pkg::SDIV_N_W'(sd_op) * mesf_pkg::SDIV_N_W'(sd_cst);
  end

  mesf_sdiv u_sdiv (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (sd_start),
    .dividend_i (sd_dividend),
    .divisor_i  (sd_divisor),
    .done_o     (sd_done),
    .quo_o      (sd_quo)
  );

  mesf_cdiv u_cdiv_rr (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (cd_vld),
    .num_i ({prr_r[mesf_pkg::PROD_W-1], prr_r}),
    .vld_o (cd_done_rr),
    .quo_o (zr2)
  );

  mesf_cdiv u_cdiv_ii (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (cd_vld),
    .num_i ({pii_r[mesf_pkg::PROD_W-1], pii_r}),
    .vld_o (cd_done_ii),
    .quo_o (zi2)
  );

  // The cross term is doubled before the division, not after.
  mesf_cdiv u_cdiv_ri (
    .clk   (clk),
    .rst_n (rst_n),
    .vld_i (cd_vld),
    .num_i ($signed({pri_r, 1'b0})),
    .vld_o (cd_done_ri),
    .quo_o (zrzi2)
  );

  assign cd_done = cd_done_rr & cd_done_ii & cd_done_ri;

  always_comb begin
    mag2   = AW'(zr2) + AW'(zi2);
    zr_new = AW'(zr2) - AW'(zi2) + AW'(cr_r);
    zi_new = AW'(zrzi2) + AW'(ci_r);
    escape = (mag2 > mesf_pkg::ESC_LIMIT);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mesf_pkg::BK_IDLE:
        if (fe_i.pend) begin
          state_nxt = empty_frame ? mesf_pkg::BK_DONE : mesf_pkg::BK_ROW;
        end
      mesf_pkg::BK_ROW:      state_nxt = mesf_pkg::BK_ROW_WAIT;
      mesf_pkg::BK_ROW_WAIT: if (sd_done) state_nxt = mesf_pkg::BK_PIX;
      mesf_pkg::BK_PIX:      state_nxt = mesf_pkg::BK_PIX_WAIT;
      mesf_pkg::BK_PIX_WAIT: if (sd_done) state_nxt = mesf_pkg::BK_MUL;
      mesf_pkg::BK_MUL:
        state_nxt = at_limit ? mesf_pkg::BK_PEND : mesf_pkg::BK_DGO;
      mesf_pkg::BK_DGO:      state_nxt = mesf_pkg::BK_DWAIT;
      mesf_pkg::BK_DWAIT:
        if (cd_done) begin
          state_nxt = escape ? mesf_pkg::BK_PEND : mesf_pkg::BK_MUL;
        end
      mesf_pkg::BK_PEND:
        if (!last_x) begin
          state_nxt = mesf_pkg::BK_PIX;
        end else begin
          state_nxt = last_y ? mesf_pkg::BK_DONE : mesf_pkg::BK_ROW;
        end
      mesf_pkg::BK_DONE:     if (out_free) state_nxt = mesf_pkg::BK_IDLE;
      default:               state_nxt = mesf_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop_o    = 1'b0;
    sd_start = 1'b0;
    cd_vld   = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      mesf_pkg::BK_IDLE: pop_o    = fe_i.pend;
      mesf_pkg::BK_ROW,
      mesf_pkg::BK_PIX:  sd_start = 1'b1;
      mesf_pkg::BK_DGO:  cd_vld   = 1'b1;
      mesf_pkg::BK_DONE: out_load = out_free;
      default: ;
    endcase
  end

  always_comb begin
    x_nxt   = x_r;
    y_nxt   = y_r;
    cr_nxt  = cr_r;
    ci_nxt  = ci_r;
    zr_nxt  = zr_r;
    zi_nxt  = zi_r;
    n_nxt   = n_r;
    sum_nxt = sum_r;
    prr_nxt = prr_r;
    pii_nxt = pii_r;
    pri_nxt = pri_r;
    unique case (state_r)
      mesf_pkg::BK_IDLE: begin
        x_nxt   = '0;
        y_nxt   = '0;
        sum_nxt = '0;
      end
      mesf_pkg::BK_ROW_WAIT:
        if (sd_done) ci_nxt = $signed({1'b0, sd_quo}) - mesf_pkg::CI_OFS;
      mesf_pkg::BK_PIX_WAIT:
        if (sd_done) begin
          cr_nxt = $signed({1'b0, sd_quo}) - mesf_pkg::CR_OFS;
          zr_nxt = '0;
          zi_nxt = '0;
          n_nxt  = '0;
        end
      mesf_pkg::BK_MUL: begin
        prr_nxt = zr_r * zr_r;
        pii_nxt = zi_r * zi_r;
        pri_nxt = zr_r * zi_r;
      end
      mesf_pkg::BK_DWAIT:
        if (cd_done && !escape) begin
          zr_nxt = zr_new[ZW-1:0];
          zi_nxt = zi_new[ZW-1:0];
          n_nxt  = n_r + 1'b1;
        end
      mesf_pkg::BK_PEND: begin
        sum_nxt = sum_r + mesf_pkg::SUM_W'(n_r);
        if (last_x) begin
          x_nxt = '0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // The result register frees the sequencer to start the next frame.
  always_comb begin
    out_data_nxt  = out_load ? sum_r : out_data_r;
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mesf_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    cr_r       <= cr_nxt;
    ci_r       <= ci_nxt;
    zr_r       <= zr_nxt;
    zi_r       <= zi_nxt;
    n_r        <= n_nxt;
    sum_r      <= sum_nxt;
    prr_r      <= prr_nxt;
    pii_r      <= pii_nxt;
    pri_r      <= pri_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_data_r};

endmodule

>>> hw/rtl/mandelbrot_escape_sum_fixed.sv
// Per start word the frame is walked row by row. Each row and each pixel waits on the
// bit-serial division for its coordinate, and each iteration passes through the three
// pipelined divide-by-million lanes.
// Frames run one at a time, so throughput is one start per frame time while results
// drain; two further starts queue at the input. Reset (rst_n low, synchronous) loads
// width 426, height 240, limit 100 and empties the start queue and the result register.
module mandelbrot_escape_sum_fixed (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,    // [0] start_req
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [39:0]                      out_tdata,   // [37:0] iteration_sum
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [mesf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mesf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  mesf_pkg::fe_t fe;
  logic          pop;

  mesf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_i     (pop),
    .fe_o      (fe)
  );

  mesf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fe_i       (fe),
    .pop_o      (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> verif/mandelbrot_escape_sum_fixed_test.sv
module mandelbrot_escape_sum_fixed_test;

  localparam int unsigned CYCLE_LIMIT  = 6_000_000;
  localparam int          SETTLE_CYCLES = 200;
  localparam int          LONG_HOLD     = 4000;
  localparam logic [mesf_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                            clk;
  logic                            rst_n      = 1'b0;
  logic                            in_tvalid  = 1'b0;
  logic                            in_tready;
  logic [7:0]                      in_tdata   = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  logic [39:0]                     out_tdata;
  logic                            cfg_valid  = 1'b0;
  logic                            cfg_ready;
  logic [mesf_pkg::CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [mesf_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

  mandelbrot_escape_sum_fixed uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  mesf_pkg::cfg_t              frame_cfg;
  logic [7:0]                  start_words[$];
  logic [mesf_pkg::SUM_W-1:0]  sums_due[$];

  int          err_cnt = 0;
  int          sums_checked = 0;
  int          starts_sent = 0;
  int          quiet_sent = 0;
  int          writes_done = 0;
  int          rnd_words = 0;
  int          rnd_starts = 0;
  int unsigned cycle_cnt = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        hold_armed = 1'b0;
  logic        hold_done = 1'b0;

  // Escape-time sum over the whole frame, millionths fixed point.
  function automatic logic [mesf_pkg::SUM_W-1:0] frame_sum(
    input logic [mesf_pkg::DIM_W-1:0]   w,
    input logic [mesf_pkg::DIM_W-1:0]   h,
    input logic [mesf_pkg::LIMIT_W-1:0] lim);
    longint      total;
    longint      cr, ci, zr, zi, zr2, zi2;
    int unsigned n;
    int          px, py;
    total = 0;
    if (w == 0 || h == 0) return '0;
    for (py = 0; py < int'(h); py++) begin
      ci = (longint'(py) * 2000000) / longint'(h) - 1000000;
      for (px = 0; px < int'(w); px++) begin
        cr = (longint'(px) * 3500000) / longint'(w) - 2500000;
        zr = 0;
        zi = 0;
        n  = 0;
        while (n < lim) begin
          zr2 = (zr * zr) / 1000000;
          zi2 = (zi * zi) / 1000000;
          if (zr2 + zi2 > 4000000) break;
          zi = (2 * zr * zi) / 1000000 + ci;
          zr = zr2 - zi2 + cr;
          n++;
        end
        total += n;
      end
    end
    return total[mesf_pkg::SUM_W-1:0];
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sender: bursts of words with random gaps, prediction made on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (in_tdata[0]) begin
          sums_due.push_back(frame_sum(frame_cfg.frame_width, frame_cfg.frame_height,
                                       frame_cfg.iteration_limit));
          starts_sent++;
        end else begin
          quiet_sent++;
        end
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left  <= gap_left - 1;
        end else if (start_words.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata  <= start_words.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 20);
            gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: short random stalls, plus one long hold-off when armed.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sums_due.size() == 0) begin
          $error("unexpected result word: iteration_sum actual %0d",
                 out_tdata[mesf_pkg::SUM_W-1:0]);
          err_cnt++;
        end else begin
          if (out_tdata[mesf_pkg::SUM_W-1:0] !== sums_due[0]) begin
            $error("iteration_sum mismatch: expected %0d, actual %0d",
                   sums_due[0], out_tdata[mesf_pkg::SUM_W-1:0]);
            err_cnt++;
          end
          void'(sums_due.pop_front());
          sums_checked++;
        end
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left  <= hold_left - 1;
      end else if (hold_armed && !hold_done) begin
        out_tready <= 1'b0;
        hold_left  <= LONG_HOLD;
        hold_done  <= 1'b1;
      end else if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 15) == 0) begin
        out_tready <= 1'b0;
        stall_left <= $urandom_range(1, 30);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [mesf_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [mesf_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      mesf_pkg::CFG_FRAME_WIDTH:
        frame_cfg.frame_width = val[mesf_pkg::DIM_W-1:0];
      mesf_pkg::CFG_FRAME_HEIGHT:
        frame_cfg.frame_height = val[mesf_pkg::DIM_W-1:0];
      mesf_pkg::CFG_ITERATION_LIMIT:
        frame_cfg.iteration_limit = val[mesf_pkg::LIMIT_W-1:0];
      default: ;
    endcase
    writes_done++;
  endtask

  task automatic set_frame(input int w, input int h, input int lim);
    write_reg(mesf_pkg::CFG_FRAME_WIDTH, mesf_pkg::CFG_DATA_W'(w));
    write_reg(mesf_pkg::CFG_FRAME_HEIGHT, mesf_pkg::CFG_DATA_W'(h));
    write_reg(mesf_pkg::CFG_ITERATION_LIMIT, mesf_pkg::CFG_DATA_W'(lim));
  endtask

  task automatic queue_word(input logic req);
    @(negedge clk);
    start_words.push_back({7'd0, req});
  endtask

  // Waits until every expected sum has arrived; a quiet word may still be
  // in flight, so a settle period follows before the block counts as idle.
  task automatic drain();
    do @(posedge clk); while (start_words.size() != 0 || in_tvalid || sums_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int  n_items;
    int  lim;
    logic req;
    frame_cfg.frame_width     = mesf_pkg::RST_FRAME_WIDTH;
    frame_cfg.frame_height    = mesf_pkg::RST_FRAME_HEIGHT;
    frame_cfg.iteration_limit = mesf_pkg::RST_ITERATION_LIMIT;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single row keeps the reset width and limit affordable.
    write_reg(mesf_pkg::CFG_FRAME_HEIGHT, 16'd1);
    queue_word(1'b1);
    queue_word(1'b0);
    drain();

    // Empty frames in either direction.
    set_frame(0, 3, 10);
    queue_word(1'b1);
    drain();
    set_frame(3, 0, 10);
    queue_word(1'b1);
    drain();

    // Largest width and height the registers hold.
    set_frame(4095, 1, 1);
    queue_word(1'b1);
    drain();
    set_frame(1, 4095, 1);
    queue_word(1'b1);
    drain();

    // Full-scale limit on a point that escapes after one iteration, then a zero limit.
    set_frame(1, 1, 65535);
    queue_word(1'b1);
    drain();
    write_reg(mesf_pkg::CFG_ITERATION_LIMIT, 16'd0);
    queue_word(1'b1);
    queue_word(1'b0);
    queue_word(1'b1);
    drain();

    // Upper data bits beyond the width field are dropped; this frame has
    // two points inside the set.
    write_reg(mesf_pkg::CFG_FRAME_WIDTH, 16'hF003);
    write_reg(mesf_pkg::CFG_FRAME_HEIGHT, 16'd2);
    write_reg(mesf_pkg::CFG_ITERATION_LIMIT, 16'd40);
    queue_word(1'b1);
    drain();

    // A write to an unused index must leave the setting alone.
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    queue_word(1'b1);
    drain();

    // Hold the output long enough that the start queue fills and stalls.
    set_frame(2, 2, 8);
    @(posedge clk);
    hold_armed <= 1'b1;
    repeat (10) queue_word(1'b1);
    drain();

    while (rnd_words < 80 || rnd_starts < 30) begin
      lim = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 32);
      set_frame($urandom_range(1, 5), $urandom_range(1, 4), lim);
      n_items = $urandom_range(4, 14);
      repeat (n_items) begin
        req = ($urandom_range(0, 3) != 0);
        queue_word(req);
        rnd_words++;
        if (req) rnd_starts++;
      end
      drain();
    end

    $display("Checked %0d frame sums from %0d start words, %0d quiet words ignored.",
             sums_checked, starts_sent, quiet_sent);
    $display("%0d register writes: empty, 4095-wide and 4095-tall frames, limits 0 to 65535.",
             writes_done);
    if (err_cnt == 0 && sums_due.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
